@@ src/rarmt_pkg.sv @@
// Shared constants and types for the range-assign range-max tree.
`default_nettype none
package rarmt_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = $clog2(MAX_ELEMENTS);
    localparam int NODE_AW      = LEVELS + 1;
    localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
    localparam int IDX_W        = 11;
    localparam int VAL_W        = 64;
    localparam int ENTRY_W      = 2 * VAL_W + 1;

    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef logic signed [VAL_W-1:0] t_val;

    // node entry: pending flag, pending value, subtree maximum
    typedef struct packed {
        logic pend;
        t_val asg;
        t_val mx;
    } t_node;
endpackage
`default_nettype wire

@@ src/range_assign_range_max_tree.sv @@
// Top level: segment tree with lazy range assignment and range maximum.
// One item at a time; a visited node passes through the read, evaluate and return states, a pending
// push adds the push state, and each node split by an assign adds the UPA, UPB and UPC states on the way up.
// An invalid word goes straight to the output state; a query covering the whole tree visits
// only the root. Input is ready again in the cycle after the result register loads.
// Synchronous active-low reset, then a clearing pass over all 2048 node entries with the input held off.
`default_nettype none
module range_assign_range_max_tree (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [10:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [87:0] i_s_tdata,  // range_low, range_high, value, zero pad
    input  wire logic [0:0]  i_s_tuser,  // action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,  // max_value
    output logic [0:0]       o_m_tuser   // range_error
);
    import rarmt_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_PUSH  = 4'd4;
    localparam logic [3:0] S_RET   = 4'd5;
    localparam logic [3:0] S_UPA   = 4'd6;
    localparam logic [3:0] S_UPB   = 4'd7;
    localparam logic [3:0] S_UPC   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]         r_state;
    logic [IDX_W-1:0]   r_len;
    logic [NODE_AW-1:0] r_clr;
    logic [NODE_AW-1:0] r_v;
    logic [3:0]         r_d;
    logic               r_act;
    logic [LEVELS-1:0]  r_ql, r_qh;
    t_val               r_val, r_acc, r_tmp, r_push, r_res;
    logic               r_err;
    logic               r_m_valid;
    t_val               r_m_data;
    logic               r_m_err;

    logic               w_we;
    logic [NODE_AW-1:0] w_waddr, w_raddr;
    t_node              w_wdata, w_rd;
    logic [ENTRY_W-1:0] w_rd_raw;
    t_val               w_cmp_a, w_cmp_b, w_cmp_max;

    logic [IDX_W-1:0]   w_ql, w_qh;
    logic               w_bad;
    logic [20:0]        w_sh;
    logic [LEVELS-1:0]  w_lo, w_hi, w_mask;
    logic               w_disj, w_cov;
    logic               w_out_free;

    rarmt_ram #(.DEPTH(NODE_DEPTH), .AW(NODE_AW), .W(ENTRY_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_raw)
    );
    assign w_rd = t_node'(w_rd_raw);

    rarmt_cmp u_cmp (.i_a(w_cmp_a), .i_b(w_cmp_b), .o_max(w_cmp_max));

    assign w_ql  = i_s_tdata[10:0];
    assign w_qh  = i_s_tdata[21:11];
    assign w_bad = (w_ql == '0) || (w_ql > w_qh) || (w_qh > r_len) ||
                   (w_qh > IDX_W'(MAX_ELEMENTS));

    // node interval, zero-based, from index and depth
    assign w_sh   = {10'b0, r_v} << (4'(LEVELS) - r_d);
    assign w_lo   = w_sh[LEVELS-1:0];
    assign w_mask = {LEVELS{1'b1}} >> r_d;
    assign w_hi   = w_lo | w_mask;
    assign w_disj = (w_hi < r_ql) || (w_lo > r_qh);
    assign w_cov  = (r_ql <= w_lo) && (w_hi <= r_qh);

    assign w_out_free = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_err;

    always_comb begin
        w_cmp_a = r_acc;
        w_cmp_b = w_rd.pend ? w_rd.asg : w_rd.mx;
        if (r_state == S_UPC) begin
            w_cmp_a = r_tmp;
            w_cmp_b = w_rd.mx;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_v;
        w_wdata = '{pend: 1'b0, asg: '0, mx: '0};
        w_raddr = r_v;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            S_EVAL: begin
                if (!w_disj && r_act == ACT_ASSIGN) begin
                    if (w_cov) begin
                        w_we    = 1'b1;
                        w_wdata = '{pend: 1'b1, asg: r_val, mx: r_val};
                    end else if (w_rd.pend) begin
                        w_we    = 1'b1;
                        w_waddr = {r_v[NODE_AW-2:0], 1'b0};
                        w_wdata = '{pend: 1'b1, asg: w_rd.asg, mx: w_rd.asg};
                    end
                end
            end
            S_PUSH: begin
                w_we    = 1'b1;
                w_waddr = {r_v[NODE_AW-2:0], 1'b1};
                w_wdata = '{pend: 1'b1, asg: r_push, mx: r_push};
            end
            S_UPA: w_raddr = {r_v[NODE_AW-2:0], 1'b0};
            S_UPB: w_raddr = {r_v[NODE_AW-2:0], 1'b1};
            S_UPC: begin
                // parent loses its pending mark: children now carry it
                w_we    = 1'b1;
                w_wdata = '{pend: 1'b0, asg: '0, mx: w_cmp_max};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_len     <= IDX_W'(MAX_ELEMENTS);
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_len <= i_cfg_wdata;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == NODE_AW'(NODE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_act <= i_s_tuser[0];
                        r_ql  <= LEVELS'(w_ql - 1'b1);
                        r_qh  <= LEVELS'(w_qh - 1'b1);
                        r_val <= i_s_tdata[85:22];
                        r_acc <= {1'b1, {(VAL_W-1){1'b0}}};
                        r_v   <= NODE_AW'(1);
                        r_d   <= '0;
                        r_err <= w_bad;
                        r_res <= '0;
                        r_state <= w_bad ? S_OUT : S_RD;
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    if (w_disj) begin
                        r_state <= S_RET;
                    end else if (r_act == ACT_QUERY) begin
                        if (w_rd.pend || w_cov) begin
                            r_acc   <= w_cmp_max;
                            r_state <= S_RET;
                        end else begin
                            r_v     <= {r_v[NODE_AW-2:0], 1'b0};
                            r_d     <= r_d + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (w_cov) begin
                        r_state <= S_RET;
                    end else if (w_rd.pend) begin
                        r_push  <= w_rd.asg;
                        r_state <= S_PUSH;
                    end else begin
                        r_v     <= {r_v[NODE_AW-2:0], 1'b0};
                        r_d     <= r_d + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_PUSH: begin
                    r_v     <= {r_v[NODE_AW-2:0], 1'b0};
                    r_d     <= r_d + 1'b1;
                    r_state <= S_RD;
                end
                S_RET: begin
                    if (r_v == NODE_AW'(1)) begin
                        r_res   <= (r_act == ACT_QUERY) ? r_acc : '0;
                        r_state <= S_OUT;
                    end else if (!r_v[0]) begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_v     <= r_v >> 1;
                        r_d     <= r_d - 1'b1;
                        r_state <= (r_act == ACT_QUERY) ? S_RET : S_UPA;
                    end
                end
                S_UPA: r_state <= S_UPB;
                S_UPB: begin
                    r_tmp   <= w_rd.mx;
                    r_state <= S_UPC;
                end
                S_UPC: r_state <= S_RET;
                S_OUT: begin
                    if (w_out_free) begin
                        r_m_data  <= r_res;
                        r_m_err   <= r_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("input accepted during clearing pass");
    a_depth_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_EVAL) |-> ((r_v >> r_d) == NODE_AW'(1)))
        else $error("node index and depth disagree");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> o_m_tvalid)
        else $error("result lost on output load");
endmodule
`default_nettype wire

@@ src/rarmt_ram.sv @@
// Simple dual-port node memory (one write port, one read port) with registered read data.
`default_nettype none
module rarmt_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int W     = 129
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ src/rarmt_cmp.sv @@
// Shared signed maximum unit.
`default_nettype none
module rarmt_cmp (
    input  wire rarmt_pkg::t_val i_a,
    input  wire rarmt_pkg::t_val i_b,
    output rarmt_pkg::t_val      o_max
);
    import rarmt_pkg::*;
    assign o_max = (i_a > i_b) ? i_a : i_b;
endmodule
`default_nettype wire
